// File: hdl/tdpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants of the trial division primality tester
// Holds the payload width of the channels and the status group that the
// remainder unit reports to the sequencer.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   // width of the candidate and echo fields on the channels
   localparam int DATA_WIDTH = 64;

   // status of the shared remainder unit
   typedef struct packed {
      logic busy;   // a remainder is being worked out
      logic done;   // one-cycle pulse, remainder is valid
   } rem_status_type;

endpackage

// File: hdl/tdpt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_ifs: valid/ready channels of the trial division primality tester
// The request channel carries one candidate per transfer, the response
// channel one echoed number and its prime flag per transfer.
// ----------------------------------------------------------------------------
interface tdpt_req_if;
   logic                            valid;
   logic                            ready;
   logic [tdpt_pkg::DATA_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tdpt_pkg::DATA_WIDTH-1:0] tested_number;
   logic                            prime_flag;

   modport source (output valid, output tested_number, output prime_flag, input ready);
   modport sink   (input valid, input tested_number, input prime_flag, output ready);
endinterface

// File: hdl/trial_division_primality_test_top.sv
`timescale 1ns / 1ps
// Flow (request to response transfer): zero, two and other even numbers are settled in
//   ST_CHECK; one and odd numbers below 9 go on to ST_BOUND only; else each odd divisor
//   tried takes one pass of the remainder unit in ST_DIVIDE before ST_BOUND again.
// Throughput: one candidate at a time; the intake reopens in the cycle after the
//   response transfer. The bit-serial remainder unit sets the pace.
// Reset: synchronous, active high; clears the sequencer state and the remainder unit's control flags.
// ----------------------------------------------------------------------------
// trial_division_primality_test_top: trial division primality tester
// Tests odd divisors 3, 5, 7, ... while divisor squared <= candidate, using
// one shared remainder unit; the square is kept incrementally.
// ----------------------------------------------------------------------------
module trial_division_primality_test_top #(
   parameter int NUMBER_WIDTH = 64
) (
   input logic clock,
   input logic reset,
   tdpt_req_if.sink   req_chan,
   tdpt_rsp_if.source rsp_chan
);

   localparam int DW      = tdpt_pkg::DATA_WIDTH;
   localparam int NW      = NUMBER_WIDTH;
   localparam int DIV_W   = (NW + 1) / 2 + 2;
   localparam int SQ_W    = NW + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BOUND,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [DIV_W-1:0]     d_ff, d_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic                 prime_ff, prime_in;

   logic                 rem_start;
   logic [DIV_W-1:0]     rem_value;
   tdpt_pkg::rem_status_type rem_status;

   tdpt_rem_unit #(
      .NUM_WIDTH (NW),
      .DIV_WIDTH (DIV_W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .rem      (rem_value),
      .status   (rem_status)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      prime_in  = prime_ff;
      rem_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               n_in     = req_chan.candidate[NW-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            d_in  = DIV_W'(3);
            sq_in = SQ_W'(9);
            if (n_ff == NW'(2)) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else if (!n_ff[0]) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            if (sq_ff > {2'b00, n_ff}) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               rem_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (rem_status.done) begin
               if (rem_value == '0) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  // (d+2)^2 = d^2 + 4d + 4
                  d_in     = d_ff + DIV_W'(2);
                  sq_in    = sq_ff + SQ_W'({d_ff, 2'b00}) + SQ_W'(4);
                  state_in = ST_BOUND;
               end
            end
         end
         ST_DONE: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      prime_ff <= prime_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // channel outputs
   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = (state_ff == ST_DONE);
   assign rsp_chan.tested_number = DW'(n_ff);
   assign rsp_chan.prime_flag    = prime_ff;

   // even numbers other than two never come out prime
   a_even_composite : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !n_ff[0] && (n_ff != NW'(2)) |-> !rsp_chan.prime_flag)
      else $error("even number flagged prime");

   // only odd divisors are tried
   a_odd_divisor : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BOUND) || (state_ff == ST_DIVIDE) |-> d_ff[0])
      else $error("even trial divisor");

   // a request transfer closes the intake until the response transfer
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready && !rsp_chan.valid)
      else $error("intake open while a candidate is in work");

endmodule

// File: hdl/tdpt_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_rem_unit: bit-serial remainder unit
// Restoring division that yields dividend mod divisor, one dividend bit per
// cycle, working through all NUM_WIDTH bits after start. Only the remainder is kept.
// ----------------------------------------------------------------------------
module tdpt_rem_unit #(
   parameter int NUM_WIDTH = 64,
   parameter int DIV_WIDTH = 34
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NUM_WIDTH-1:0]     dividend,
   input  logic [DIV_WIDTH-1:0]     divisor,
   output logic [DIV_WIDTH-1:0]     rem,
   output tdpt_pkg::rem_status_type status
);

   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DIV_WIDTH-1:0] div_ff, div_in;
   logic [DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_WIDTH:0]   trial;
   logic [DIV_WIDTH:0]   diff;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   assign trial = {rem_ff, dvd_ff[NUM_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_WIDTH'(NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[NUM_WIDTH-2:0], 1'b0};
         rem_in = (trial >= {1'b0, div_ff}) ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // busy and done flags reset; datapath and bit counter do not
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rem         = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // remainder is always reduced below the divisor
   a_rem_reduced : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   // a new start never lands on a running division
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("start while busy");

   // done only closes a running division
   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff) && !busy_ff)
      else $error("done without a division");

endmodule
